@@ rtl/core/mm2_pkg.sv @@
package mm2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd5381;

    // queue depth must be a power of two (pointers wrap naturally)
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_TAIL = 2'd1;
    localparam kind_t KIND_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] word;
        logic [30:0] len;
        kind_t       kind;
        logic        first;
        logic        last;
        logic        err_set;
    } entry_t;

    function automatic logic [31:0] tail_mask(input logic [1:0] n);
        logic [31:0] m;
        case (n)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/mm2_queue.sv @@
module mm2_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mm2_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output mm2_pkg::entry_t head
);
    import mm2_pkg::*;

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/core/mm2_front.sv @@
module mm2_front (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [31:0]     key_word,
    input  logic [2:0]      valid_bytes,
    input  logic            first_word,
    input  logic            last_word,
    input  logic [30:0]     key_length,
    input  logic            q_full,
    output logic            q_push,
    output mm2_pkg::entry_t q_entry
);
    import mm2_pkg::*;

    kind_t kind;

    // 4..7 bytes count as a full word
    always_comb
    begin
        if (valid_bytes[2])
            kind = KIND_FULL;
        else if (valid_bytes[1:0] == 2'd0)
            kind = KIND_NONE;
        else
            kind = KIND_TAIL;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.word    = (kind == KIND_FULL) ? key_word
                                              : (key_word & tail_mask(valid_bytes[1:0]));
        q_entry.len     = key_length;
        q_entry.kind    = kind;
        q_entry.first   = first_word;
        q_entry.last    = last_word;
        q_entry.err_set = (kind != KIND_FULL) && !last_word;
    end

endmodule

@@ rtl/core/mm2_back.sv @@
module mm2_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [31:0]     cfg_data,
    input  logic            q_empty,
    input  mm2_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     hash_value,
    output logic            framing_error
);
    import mm2_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FULL1 = 3'd1;
    localparam logic [2:0] S_FULL2 = 3'd2;
    localparam logic [2:0] S_FULL3 = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg, h_next;
    logic        err_reg, err_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] k_reg, k_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic        out_err_reg, out_err_next;

    logic [31:0] mul_a;
    logic [31:0] product;
    logic [31:0] fin_hash;
    logic        out_free;

    // one shared multiplier by the mix constant, operand picked per step
    always_comb
    begin
        unique case (state_reg)
            S_FULL1: mul_a = k_reg;
            S_FULL2: mul_a = k_reg ^ (k_reg >> MIX_SHIFT);
            S_FULL3: mul_a = h_reg;
            S_TAIL:  mul_a = h_reg ^ k_reg;
            S_FIN:   mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default: mul_a = '0;
        endcase
    end

    assign product  = mul_a * MIX_MUL;
    assign fin_hash = product ^ (product >> FIN_SHIFT_B);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        err_next       = err_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        seed_next      = cfg_write ? cfg_data : seed_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    k_next    = q_head.word;
                    last_next = q_head.last;
                    if (q_head.first)
                    begin
                        h_next   = seed_reg ^ {1'b0, q_head.len};
                        err_next = q_head.err_set;
                    end
                    else
                        err_next = err_reg | q_head.err_set;
                    unique case (q_head.kind)
                        KIND_FULL: state_next = S_FULL1;
                        KIND_TAIL: state_next = S_TAIL;
                        default:   state_next = q_head.last ? S_FIN : S_IDLE;
                    endcase
                end
            end
            S_FULL1:
            begin
                k_next     = product;
                state_next = S_FULL2;
            end
            S_FULL2:
            begin
                k_next     = product;
                state_next = S_FULL3;
            end
            S_FULL3:
            begin
                h_next     = product ^ k_reg;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_TAIL:
            begin
                h_next     = product;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_hash;
                    out_err_next   = err_reg;
                    h_next         = '0;
                    err_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg         <= '0;
            err_reg       <= 1'b0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            err_reg       <= err_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        last_reg     <= last_next;
        out_hash_reg <= out_hash_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid     = out_valid_reg;
    assign hash_value    = out_hash_reg;
    assign framing_error = out_err_reg;

endmodule

@@ rtl/core/murmur2_key_hasher.sv @@
// Streaming 32-bit MurmurHash2 of a key sent as little-endian words.
// Input request: key_word, valid_bytes, first_word, last_word, key_length;
// taken when in_valid is high and in_stall is low. key_length is used only
// on a word marked first_word. One result request (hash_value,
// framing_error) leaves on out_valid/out_stall for each word marked last.
// Flow: a request goes into a two-entry queue, then a sequencer runs it
// through one shared 32x32 multiplier by the mix constant. The sequencer
// pops a word in its idle step, then runs a full word through the steps
// FULL1, FULL2 and FULL3, a 1..3 byte tail through the TAIL step and an
// empty word through none, plus the FIN step on the last word; it pops
// the next word only once done with the last. The user writes hash_seed
// with cfg_write/cfg_data only while the block is idle; nothing enforces it.
// Reset clears the queue, the running hash and error flag, drops
// out_valid and loads the seed with 5381. While out_stall holds, the
// result stays on the port; once it has a new result the sequencer waits
// in its finish step and the queue keeps taking requests until it is full.
module murmur2_key_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] key_word,
    input  logic [2:0]  valid_bytes,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [30:0] key_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value,
    output logic        framing_error
);
    import mm2_pkg::*;

    entry_t q_entry;
    entry_t q_head;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    mm2_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_word    (key_word),
        .valid_bytes (valid_bytes),
        .first_word  (first_word),
        .last_word   (last_word),
        .key_length  (key_length),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    mm2_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    mm2_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hash_value    (hash_value),
        .framing_error (framing_error)
    );

endmodule

@@ rtl/core/mm2_checker.sv @@
module mm2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] hash_value,
    input logic        framing_error
);

    // coming out of reset the output slot is empty
    a_reset_out_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    // coming out of reset the queue is empty, so input is not stalled
    a_reset_in_open: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_stall)
        else $error("in_stall high right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hash_value) && $stable(framing_error))
        else $error("result changed while stalled");

endmodule

bind murmur2_key_hasher mm2_checker u_mm2_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hash_value    (hash_value),
    .framing_error (framing_error)
);
